// File: hdl/slwp_pkg.sv
// shared types and constants of the serial loaded wave player
// depends on nothing; used by every module of the block except slwp_ram
package slwp_pkg;

    localparam int WAVE_DEPTH  = 1024;
    localparam int ADDR_W      = $clog2(WAVE_DEPTH);
    localparam int SAMPLE_W    = 8;
    localparam int BUF_SIZE_W  = 11;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
    localparam int GROUP_LEN   = 5;
    localparam int GROUP_W     = 3;
    localparam int OUT_TDATA_W = 16;

    localparam logic [BUF_SIZE_W-1:0] BUF_SIZE_RESET = BUF_SIZE_W'(1024);
    localparam logic [ADDR_W-1:0]     LAST_INDEX     = ADDR_W'(WAVE_DEPTH - 1);
    localparam logic [GROUP_W-1:0]    GROUP_RESET    = GROUP_W'((WAVE_DEPTH - 1) % GROUP_LEN);
    localparam logic [GROUP_W-1:0]    GROUP_LAST     = GROUP_W'(GROUP_LEN - 1);

    // serial characters
    localparam logic [7:0] CH_START = 8'h42;
    localparam logic [7:0] CH_SET   = 8'h53;
    localparam logic [7:0] CH_TIME  = 8'h54;

    // command kinds passed from parser to playback
    localparam logic [2:0] KIND_NOP   = 3'd0;
    localparam logic [2:0] KIND_ACK   = 3'd1;
    localparam logic [2:0] KIND_WRITE = 3'd2;
    localparam logic [2:0] KIND_DELAY = 3'd3;
    localparam logic [2:0] KIND_TICK  = 3'd4;

    typedef struct packed {
        logic [2:0]          kind;
        logic [ADDR_W-1:0]   addr;
        logic [SAMPLE_W-1:0] data;
    } t_cmd;

endpackage

// File: hdl/slwp_ram.sv
// generic single-port ram with registered read
// no dependencies
module slwp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_en,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_we) begin
                r_mem[i_addr] <= i_wdata;
            end else begin
                r_rdata <= r_mem[i_addr];
            end
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: hdl/slwp_front.sv
// command parser: classifies serial bytes and ticks into queue commands
// depends on slwp_pkg
module slwp_front
    import slwp_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    input  logic [BUF_SIZE_W-1:0] i_cfg_data,
    input  logic                  i_accept,
    input  logic                  i_op,
    input  logic [7:0]            i_rx_byte,
    output logic                  o_push,
    output t_cmd                  o_cmd
);

    localparam logic [2:0] ST_WAIT   = 3'd0;
    localparam logic [2:0] ST_CMD    = 3'd1;
    localparam logic [2:0] ST_ADDR_H = 3'd2;
    localparam logic [2:0] ST_ADDR_L = 3'd3;
    localparam logic [2:0] ST_VALUE  = 3'd4;
    localparam logic [2:0] ST_TIME   = 3'd5;

    logic [2:0]            r_state, n_state;
    logic [15:0]           r_addr, n_addr;
    logic [BUF_SIZE_W-1:0] r_buf_size;
    logic                  in_range;

    assign in_range = (r_addr < {{(16 - BUF_SIZE_W){1'b0}}, r_buf_size})
                   && (r_addr < 16'(WAVE_DEPTH));

    always_comb begin
        n_state    = r_state;
        n_addr     = r_addr;
        o_cmd.kind = KIND_NOP;
        o_cmd.addr = r_addr[ADDR_W-1:0];
        o_cmd.data = i_rx_byte;
        if (i_op) begin
            o_cmd.kind = KIND_TICK;
        end else begin
            unique case (r_state)
                ST_WAIT: begin
                    n_state = (i_rx_byte == CH_START) ? ST_CMD : ST_WAIT;
                end
                ST_CMD: begin
                    priority if (i_rx_byte == CH_SET) begin
                        n_state = ST_ADDR_H;
                    end else if (i_rx_byte == CH_TIME) begin
                        n_state = ST_TIME;
                    end else begin
                        n_state = ST_WAIT;
                    end
                end
                ST_ADDR_H: begin
                    n_addr  = {i_rx_byte, 8'h00};
                    n_state = ST_ADDR_L;
                end
                ST_ADDR_L: begin
                    n_addr  = {r_addr[15:8], i_rx_byte};
                    n_state = ST_VALUE;
                end
                ST_VALUE: begin
                    o_cmd.kind = in_range ? KIND_WRITE : KIND_ACK;
                    n_state    = ST_WAIT;
                end
                ST_TIME: begin
                    o_cmd.kind = KIND_DELAY;
                    n_state    = ST_WAIT;
                end
                default: begin
                    n_state = ST_WAIT;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_WAIT;
            r_addr     <= '0;
            r_buf_size <= BUF_SIZE_RESET;
        end else begin
            if (i_cfg_valid) begin
                r_buf_size <= i_cfg_data;
            end
            if (i_accept) begin
                r_state <= n_state;
                r_addr  <= n_addr;
            end
        end
    end

    assign o_push = i_accept;

endmodule

// File: hdl/slwp_queue.sv
// short command queue between parser and playback
// depends on slwp_pkg
module slwp_queue
    import slwp_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    input  logic i_pop,
    output logic o_valid,
    output logic o_full,
    output t_cmd o_cmd
);

    t_cmd              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            unique case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    assign o_valid = (r_count != '0);
    assign o_full  = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_cmd   = r_mem[r_rd_ptr];

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full && !i_pop))
        else $error("command queue overflow");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_pop && !o_valid))
        else $error("command queue underflow");

endmodule

// File: hdl/slwp_back.sv
// playback engine: wave store, clearing pass, tick sequencing, output register
// depends on slwp_pkg and slwp_ram
module slwp_back
    import slwp_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_q_valid,
    input  t_cmd                   i_cmd,
    output logic                   o_pop,
    output logic                   o_clearing,
    output logic                   o_m_tvalid,
    input  logic                   i_m_tready,
    output logic [OUT_TDATA_W-1:0] o_m_tdata
);

    logic                r_clearing;
    logic [ADDR_W-1:0]   r_clr_cnt;
    logic [SAMPLE_W-1:0] r_delay;
    logic [SAMPLE_W-1:0] r_hold;
    logic [ADDR_W-1:0]   r_index;
    logic [GROUP_W-1:0]  r_group;
    logic                r_phase;
    logic [SAMPLE_W-1:0] r_cur_sample;
    logic                r_b_valid;
    logic                r_b_ack;
    logic                r_b_changed;
    logic                r_b_phase;

    logic                advance;
    logic                is_tick;
    logic                step;
    logic [ADDR_W-1:0]   next_index;
    logic [GROUP_W-1:0]  next_group;
    logic                ram_en;
    logic                ram_we;
    logic [ADDR_W-1:0]   ram_addr;
    logic [SAMPLE_W-1:0] ram_wdata;
    logic [SAMPLE_W-1:0] ram_rdata;
    logic [SAMPLE_W-1:0] sample;

    assign advance = !r_b_valid || i_m_tready;
    assign o_pop   = i_q_valid && advance && !r_clearing;
    assign is_tick = (i_cmd.kind == KIND_TICK);
    // tick that moves to the next sample instead of holding
    assign step    = o_pop && is_tick && (r_hold == '0);

    assign next_index = (r_index == LAST_INDEX) ? '0 : r_index + 1'b1;
    assign next_group = ((r_index == LAST_INDEX) || (r_group == GROUP_LAST))
                      ? '0 : r_group + 1'b1;

    always_comb begin
        ram_en    = 1'b0;
        ram_we    = 1'b0;
        ram_addr  = next_index;
        ram_wdata = i_cmd.data;
        if (r_clearing) begin
            ram_en    = 1'b1;
            ram_we    = 1'b1;
            ram_addr  = r_clr_cnt;
            ram_wdata = '0;
        end else if (o_pop && (i_cmd.kind == KIND_WRITE)) begin
            ram_en   = 1'b1;
            ram_we   = 1'b1;
            ram_addr = i_cmd.addr;
        end else if (step) begin
            ram_en = 1'b1;
        end
    end

    slwp_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (WAVE_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_en    (ram_en),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata (ram_wdata),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing   <= 1'b1;
            r_clr_cnt    <= '0;
            r_delay      <= '0;
            r_hold       <= '0;
            r_index      <= LAST_INDEX;
            r_group      <= GROUP_RESET;
            r_phase      <= 1'b0;
            r_cur_sample <= '0;
            r_b_valid    <= 1'b0;
            r_b_ack      <= 1'b0;
            r_b_changed  <= 1'b0;
            r_b_phase    <= 1'b0;
        end else begin
            if (r_clearing) begin
                r_clr_cnt <= r_clr_cnt + 1'b1;
                if (r_clr_cnt == LAST_INDEX) begin
                    r_clearing <= 1'b0;
                end
            end
            if (r_b_valid && i_m_tready && r_b_changed) begin
                r_cur_sample <= ram_rdata;
            end
            if (o_pop) begin
                r_b_valid   <= 1'b1;
                r_b_ack     <= (i_cmd.kind == KIND_ACK) || (i_cmd.kind == KIND_WRITE)
                            || (i_cmd.kind == KIND_DELAY);
                r_b_changed <= step;
                r_b_phase   <= step ? (r_phase ^ (next_index == '0)) : r_phase;
                if (i_cmd.kind == KIND_DELAY) begin
                    r_delay <= i_cmd.data;
                end
                if (is_tick) begin
                    if (r_hold != '0) begin
                        r_hold <= r_hold - 1'b1;
                    end else begin
                        r_index <= next_index;
                        r_group <= next_group;
                        r_phase <= r_phase ^ (next_index == '0);
                        r_hold  <= (next_group != '0) ? r_delay : '0;
                    end
                end
            end else if (i_m_tready) begin
                r_b_valid <= 1'b0;
            end
        end
    end

    assign sample     = r_b_changed ? ram_rdata : r_cur_sample;
    assign o_clearing = r_clearing;
    assign o_m_tvalid = r_b_valid;
    assign o_m_tdata  = {{(OUT_TDATA_W - SAMPLE_W - 3){1'b0}},
                         r_b_phase, r_b_changed, sample, r_b_ack};

    a_no_pop_while_clearing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clearing |-> !o_pop)
        else $error("command taken during clearing pass");

    a_hold_keeps_sample: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pop && is_tick && (r_hold != '0)) |=> (r_b_valid && !r_b_changed))
        else $error("held tick advanced the sample");

    a_changed_no_ack: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_b_valid && r_b_changed) |-> !r_b_ack)
        else $error("tick result carries an acknowledge");

    a_stalled_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_b_valid && !i_m_tready) |=> ($stable(o_m_tdata) && r_b_valid))
        else $error("stalled result changed");

endmodule

// File: hdl/serial_loaded_wave_player.sv
// top level of the serial loaded wave player
// depends on slwp_pkg, slwp_front, slwp_queue, slwp_back (and slwp_ram below it)

// Waveform player loaded over a serial byte stream. Each input transaction is
// either a serial command byte (tuser = 0) or a playback tick (tuser = 1), and
// each one yields exactly one output transaction. The parser waits for 'B',
// then 'S' (address high, address low, value: write to the wave store) or
// 'T' (one byte: hold delay); the last byte of either command is acknowledged.
// Ticks walk the store in a loop; samples at indexes not a multiple of five
// are held for the hold delay in extra ticks, and the pass phase toggles each
// time the index wraps to zero. Throughput is one transaction per cycle unless
// the queue is full, the store is being cleared or the output stalls: each item
// needs at most one access of the single-port wave store, the limiting resource.
// A transaction is registered in the queue after the parser, then with its
// store access in the output register. After reset all WAVE_DEPTH (1024) store
// entries are cleared with no input taken; buffer_size writes are always taken.
module serial_loaded_wave_player
    import slwp_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // configuration: buffer_size
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [BUF_SIZE_W-1:0]  i_cfg_data,
    // input stream
    input  logic                   i_s_tvalid,
    output logic                   o_s_tready,
    input  logic [7:0]             i_s_tdata,   // [7:0] rx_byte
    input  logic                   i_s_tuser,   // [0] op
    // result stream
    output logic                   o_m_tvalid,
    input  logic                   i_m_tready,
    output logic [OUT_TDATA_W-1:0] o_m_tdata    // [0] ack, [8:1] sample,
                                                // [9] sample_changed, [10] pass_phase
);

    logic accept;
    logic push;
    t_cmd push_cmd;
    logic q_valid;
    logic q_full;
    t_cmd q_cmd;
    logic pop;
    logic clearing;

    // register writes are always taken
    assign o_cfg_ready = 1'b1;

    // input side only stalls on a full queue or the clearing pass
    assign o_s_tready = !q_full && !clearing;
    assign accept     = i_s_tvalid && o_s_tready;

    slwp_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_accept    (accept),
        .i_op        (i_s_tuser),
        .i_rx_byte   (i_s_tdata),
        .o_push      (push),
        .o_cmd       (push_cmd)
    );

    slwp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_full  (q_full),
        .o_cmd   (q_cmd)
    );

    slwp_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_valid  (q_valid),
        .i_cmd      (q_cmd),
        .o_pop      (pop),
        .o_clearing (clearing),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

endmodule

// File: dv/tb_serial_loaded_wave_player.sv
// self-checking testbench for serial_loaded_wave_player: command bytes and playback ticks
// are driven over the input stream and every output transaction is checked against a model
// depends on slwp_pkg and the serial_loaded_wave_player rtl
module tb_serial_loaded_wave_player
    import slwp_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    // kind of input transaction, carried on tuser
    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_TICK = 1'b1;

    // 'G' is not a command of this block and sends the parser back to waiting
    localparam logic [7:0] CH_GET = 8'h47;

    // generous run limit: ~1450 items plus the store clear
    localparam int LIMIT_CYCLES = 200000;

    // command parser position
    typedef enum logic [2:0] {
        PS_IDLE, PS_CMD, PS_ADDR_HI, PS_ADDR_LO, PS_VALUE, PS_DELAY
    } t_parse;

    // one output word, same bit order as o_m_tdata from bit 0 up
    typedef struct packed {
        logic                phase;
        logic                changed;
        logic [SAMPLE_W-1:0] wave_sample;
        logic                ack;
    } t_out_word;

    // player model and queue of outputs still to come
    class player_scoreboard;
        logic [BUF_SIZE_W-1:0] buffer_size;
        t_parse                parse_st;
        logic [15:0]           write_addr;
        logic [7:0]            hold_delay;
        logic [SAMPLE_W-1:0]   wave_store [WAVE_DEPTH];
        logic [ADDR_W-1:0]     play_idx;
        logic [7:0]            hold_cnt;
        logic                  phase_level;
        logic [SAMPLE_W-1:0]   cur_level;
        t_out_word             awaited_outputs [$];
        int                    errors;

        function new();
            buffer_size = BUF_SIZE_RESET;
            parse_st    = PS_IDLE;
            write_addr  = '0;
            hold_delay  = '0;
            foreach (wave_store[i]) wave_store[i] = '0;
            play_idx    = LAST_INDEX;
            hold_cnt    = '0;
            phase_level = 1'b0;
            cur_level   = '0;
            errors      = 0;
        endfunction

        // serial command parser, returns the acknowledge
        function logic parse_byte(logic [7:0] b);
            logic ack;
            ack = 1'b0;
            case (parse_st)
                PS_IDLE: begin
                    parse_st = (b == CH_START) ? PS_CMD : PS_IDLE;
                end
                PS_CMD: begin
                    if (b == CH_SET) parse_st = PS_ADDR_HI;
                    else if (b == CH_TIME) parse_st = PS_DELAY;
                    else parse_st = PS_IDLE;
                end
                PS_ADDR_HI: begin
                    write_addr = {b, 8'h00};
                    parse_st   = PS_ADDR_LO;
                end
                PS_ADDR_LO: begin
                    write_addr = write_addr + 16'(b);
                    parse_st   = PS_VALUE;
                end
                PS_VALUE: begin
                    ack = 1'b1;
                    // out-of-range writes are dropped but still acknowledged
                    if (write_addr < 16'(buffer_size) && write_addr < 16'(WAVE_DEPTH))
                        wave_store[write_addr[ADDR_W-1:0]] = b;
                    parse_st = PS_IDLE;
                end
                PS_DELAY: begin
                    hold_delay = b;
                    ack        = 1'b1;
                    parse_st   = PS_IDLE;
                end
                default: begin
                    parse_st = PS_IDLE;
                end
            endcase
            return ack;
        endfunction

        // playback tick, returns 1 when a new sample is taken
        function logic play_tick();
            if (hold_cnt != 0) begin
                hold_cnt = hold_cnt - 8'd1;
                return 1'b0;
            end
            play_idx = (play_idx == LAST_INDEX) ? '0 : play_idx + 1'b1;
            if (play_idx == '0) phase_level = ~phase_level;
            cur_level = wave_store[play_idx];
            hold_cnt  = (play_idx % GROUP_LEN != 0) ? hold_delay : 8'd0;
            return 1'b1;
        endfunction

        function void note_input(logic op, logic [7:0] b);
            t_out_word w;
            w = '0;
            if (op == OP_BYTE) w.ack = parse_byte(b);
            else w.changed = play_tick();
            w.wave_sample = cur_level;
            w.phase       = phase_level;
            awaited_outputs.push_back(w);
        endfunction

        function void check_output(logic [OUT_TDATA_W-1:0] data);
            t_out_word got;
            t_out_word want;
            got = data[$bits(t_out_word)-1:0];
            if (awaited_outputs.size() == 0) begin
                $error("unexpected output transaction, tdata %h", data);
                errors++;
                return;
            end
            want = awaited_outputs.pop_front();
            if (got.ack !== want.ack) begin
                $error("ack: expected %0d, actual %0d", want.ack, got.ack);
                errors++;
            end
            if (got.wave_sample !== want.wave_sample) begin
                $error("sample: expected %0d, actual %0d", want.wave_sample, got.wave_sample);
                errors++;
            end
            if (got.changed !== want.changed) begin
                $error("sample_changed: expected %0d, actual %0d", want.changed, got.changed);
                errors++;
            end
            if (got.phase !== want.phase) begin
                $error("pass_phase: expected %0d, actual %0d", want.phase, got.phase);
                errors++;
            end
        endfunction

        function int outstanding();
            return awaited_outputs.size();
        endfunction
    endclass

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_cfg_valid;
    logic                   o_cfg_ready;
    logic [BUF_SIZE_W-1:0]  i_cfg_data;
    logic                   i_s_tvalid;
    logic                   o_s_tready;
    logic [7:0]             i_s_tdata;   // [7:0] rx_byte
    logic                   i_s_tuser;   // [0] op
    logic                   o_m_tvalid;
    logic                   i_m_tready;
    logic [OUT_TDATA_W-1:0] o_m_tdata;   // [0] ack, [8:1] sample, [9] sample_changed,
                                         // [10] pass_phase

    player_scoreboard sb = new();

    int send_idle_pct = 0;   // chance in percent that the sender pauses
    int recv_idle_pct = 0;   // chance in percent that the receiver stalls
    int items_sent    = 0;
    int cycles        = 0;

    serial_loaded_wave_player DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata)
    );

    // 12 ns clock
    initial i_clk = 1'b0;
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYCLES) begin
            $display("simulation failed");
            $finish;
        end
    end

    // result side: outputs are read before this edge's updates land, so a
    // transaction is taken when valid and ready were both high going in
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) sb.check_output(o_m_tdata);
        i_m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // one input transaction; the sender may pause first, valid drops only then
    task automatic send_item(logic op, logic [7:0] b);
        if ($urandom_range(99) < send_idle_pct) begin
            i_s_tvalid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= b;
        i_s_tuser  <= op;
        do @(posedge i_clk); while (!o_s_tready);
        sb.note_input(op, b);
        items_sent++;
    endtask

    task automatic send_tick();
        send_item(OP_TICK, 8'($urandom_range(0, 255)));   // byte is don't-care on a tick
    endtask

    // 'B' 'S' addr_hi addr_lo value
    task automatic send_set(logic [7:0] hi, logic [7:0] lo, logic [7:0] value);
        send_item(OP_BYTE, CH_START);
        send_item(OP_BYTE, CH_SET);
        send_item(OP_BYTE, hi);
        send_item(OP_BYTE, lo);
        send_item(OP_BYTE, value);
    endtask

    // 'B' 'T' delay
    task automatic send_delay(logic [7:0] d);
        send_item(OP_BYTE, CH_START);
        send_item(OP_BYTE, CH_TIME);
        send_item(OP_BYTE, d);
    endtask

    // stop sending and let all outstanding outputs arrive
    task automatic wait_quiet();
        i_s_tvalid <= 1'b0;
        while (sb.outstanding() != 0) @(posedge i_clk);
        repeat (6) @(posedge i_clk);
    endtask

    // buffer_size write, only called while the block is quiet
    task automatic write_buffer_size(logic [BUF_SIZE_W-1:0] v);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        sb.buffer_size = v;
    endtask

    // mostly well-formed commands and tick bursts, some noise and cut-off commands
    task automatic run_random(int n_items);
        int          stop_at;
        int          roll;
        logic [7:0]  hi;
        logic [7:0]  d;
        stop_at = items_sent + n_items;
        while (items_sent < stop_at) begin
            roll = $urandom_range(99);
            if (roll < 40) begin
                repeat ($urandom_range(1, 12)) send_tick();
            end else if (roll < 72) begin
                // addresses mostly inside the store, sometimes far out
                hi = ($urandom_range(99) < 85) ? 8'($urandom_range(0, 3))
                                               : 8'($urandom_range(0, 255));
                send_set(hi, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
            end else if (roll < 82) begin
                // short holds keep playback moving; long ones now and then
                roll = $urandom_range(99);
                if (roll < 70) d = 8'd0;
                else if (roll < 95) d = 8'($urandom_range(1, 4));
                else d = 8'($urandom_range(0, 255));
                send_delay(d);
            end else if (roll < 90) begin
                // cut-off set command; following bytes land in the address slots
                send_item(OP_BYTE, CH_START);
                send_item(OP_BYTE, CH_SET);
                if ($urandom_range(1)) send_item(OP_BYTE, 8'($urandom_range(0, 255)));
            end else begin
                repeat ($urandom_range(1, 3))
                    send_item(OP_BYTE, ($urandom_range(99) < 30) ? CH_START
                                                                 : 8'($urandom_range(0, 255)));
            end
        end
    endtask

    initial begin
        i_rst_n     <= 1'b0;
        i_cfg_valid <= 1'b0;
        i_cfg_data  <= '0;
        i_s_tvalid  <= 1'b0;
        i_s_tdata   <= '0;
        i_s_tuser   <= OP_BYTE;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // phase 1: sender idles 37%, receiver 82%
        send_idle_pct = 37;
        recv_idle_pct = 82;
        write_buffer_size(BUF_SIZE_RESET);

        // directed: first tick wraps to index 0 and flips the pass phase
        send_tick();
        send_delay(8'h02);
        send_set(8'h00, 8'h01, 8'h5a);      // in range
        send_set(8'h04, 8'h00, 8'h77);      // address 1024, past the store
        send_set(8'hff, 8'hff, 8'hff);      // highest address, dropped
        // unknown commands drop back to waiting: 'G' and a second 'B'
        send_item(OP_BYTE, CH_START);
        send_item(OP_BYTE, CH_GET);
        send_item(OP_BYTE, CH_START);
        send_item(OP_BYTE, CH_START);
        // index 1 picks up 0x5a and is held for two ticks
        repeat (4) send_tick();
        send_item(OP_BYTE, 8'h00);
        wait_quiet();

        write_buffer_size(BUF_SIZE_W'($urandom_range(1, WAVE_DEPTH - 1)));
        run_random(150);
        wait_quiet();

        // phase 2: roles swapped, nothing can be written
        send_idle_pct = 82;
        recv_idle_pct = 37;
        write_buffer_size('0);
        run_random(150);
        wait_quiet();

        // phase 3: no idling, widest buffer_size, then WAVE_DEPTH + 8 ticks with the hold delay at zero
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_buffer_size('1);
        run_random(90);
        send_delay(8'h00);
        repeat (WAVE_DEPTH + 8) send_tick();
        wait_quiet();

        if (sb.errors == 0) $display("simulation ok");
        else $display("simulation failed");
        $finish;
    end

endmodule

// File: files.f
hdl/slwp_pkg.sv
hdl/slwp_ram.sv
hdl/slwp_front.sv
hdl/slwp_queue.sv
hdl/slwp_back.sv
hdl/serial_loaded_wave_player.sv
dv/tb_serial_loaded_wave_player.sv
